// File: hw/rtl/assert_macros.svh
// assertion macros for the top level, which checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hw/rtl/drc_pkg.sv
// shared types, codes and helpers of the direct-mapped read cache
package drc_pkg;

   localparam int ADDR_W      = 32;
   localparam int DATA_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 32;
   localparam int BEAT_BYTES  = 8;
   localparam int BYTE_SEL_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      STAT_DATA   = 2'd0,
      STAT_REFILL = 2'd1,
      STAT_BEAT   = 2'd2,
      STAT_ERROR  = 2'd3
   } status_type;

   typedef enum logic {
      OP_READ = 1'b0,
      OP_FILL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOKUP
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
   } item_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   read_byte;
      logic                was_hit;
      logic [ADDR_W-1:0]   refill_address;
   } result_type;

   typedef struct packed {
      logic pop;
      logic hold;
   } back_ctl_type;

   // pick one byte out of a 64-bit line word
   function automatic logic [BYTE_W-1:0] byte_of(input logic [DATA_W-1:0] word,
                                                 input logic [BYTE_SEL_W-1:0] sel);
      return word[{sel, 3'b000} +: BYTE_W];
   endfunction

endpackage

// File: hw/rtl/drc_queue.sv
// two-entry item queue between the front and the back of the cache
module drc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  drc_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output drc_pkg::item_type  head,
   output logic               head_valid
);

   localparam int PTR_W = $clog2(drc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(drc_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(drc_pkg::QUEUE_DEPTH);

   drc_pkg::item_type  entry_ff [drc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // status toward both sides
   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/drc_front.sv
// front end: takes request items, classifies and masks them, queues them
module drc_front #(
   parameter int ADDR_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [drc_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [drc_pkg::DATA_W-1:0]    req_fill_data,
   input  drc_pkg::back_ctl_type         ctl,
   output drc_pkg::item_type             head,
   output logic                          head_valid
);

   localparam int EFF_BITS = (ADDR_BITS < drc_pkg::ADDR_W) ? ADDR_BITS : drc_pkg::ADDR_W;
   localparam logic [drc_pkg::ADDR_W-1:0] ADDR_ONE = 1;
   localparam logic [drc_pkg::ADDR_W-1:0] ADDR_MASK =
      (EFF_BITS >= drc_pkg::ADDR_W) ? '1 : ((ADDR_ONE << EFF_BITS) - ADDR_ONE);

   drc_pkg::item_type item;
   logic              full;
   logic              push;

   // classify the item and drop address bits above the address width
   always_comb begin
      item.op   = req_kind ? drc_pkg::OP_FILL : drc_pkg::OP_READ;
      item.addr = req_byte_address & ADDR_MASK;
      item.data = req_fill_data;
   end

   // no items during the tag clear pass
   assign req_ready = !full && !ctl.hold;
   assign push      = req_valid && req_ready;

   drc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (item),
      .full       (full),
      .pop        (ctl.pop),
      .head       (head),
      .head_valid (head_valid)
   );

endmodule

// File: hw/rtl/drc_back.sv
// back end: tag and data arrays, lookup, refill sequencing and counters
module drc_back #(
   parameter int NUM_SETS   = 8,
   parameter int LINE_BYTES = 32,
   parameter int ADDR_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  drc_pkg::item_type             head,
   input  logic                          head_valid,
   output drc_pkg::back_ctl_type         ctl,
   output drc_pkg::result_type           res,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic [drc_pkg::COUNT_W-1:0]   hits,
   output logic [drc_pkg::COUNT_W-1:0]   misses
);

   localparam int ADDR_W    = drc_pkg::ADDR_W;
   localparam int OFF_W     = $clog2(LINE_BYTES);
   localparam int SET_W     = $clog2(NUM_SETS);
   localparam int BEATS     = LINE_BYTES / drc_pkg::BEAT_BYTES;
   localparam int LOG_BEATS = $clog2(BEATS);
   localparam int BEAT_W    = (BEATS > 1) ? LOG_BEATS : 1;
   localparam int WORDS     = NUM_SETS * BEATS;
   localparam int WORD_W    = SET_W + LOG_BEATS;
   localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int TAG_LSB   = OFF_W + SET_W;
   localparam int TAG_W     = (EFF_BITS > TAG_LSB) ? EFF_BITS - TAG_LSB : 1;
   localparam int SEL_W     = drc_pkg::BYTE_SEL_W;
   localparam logic [ADDR_W-1:0] ADDR_ONE  = 1;
   localparam logic [ADDR_W-1:0] OFF_ONES  = (ADDR_ONE << OFF_W) - ADDR_ONE;
   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BEATS - 1);
   localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(NUM_SETS - 1);

   // tag array entry: valid bit over the tag
   logic [TAG_W:0]               tag_mem [NUM_SETS];
   logic [drc_pkg::DATA_W-1:0]   word_mem [WORDS];
   logic [TAG_W:0]               tag_rd_ff;
   logic [drc_pkg::DATA_W-1:0]   word_rd_ff;

   logic                         tag_re, tag_we, word_re, word_we;
   logic [SET_W-1:0]             tag_raddr, tag_waddr;
   logic [TAG_W:0]               tag_wdata;
   logic [WORD_W-1:0]            word_raddr, word_waddr;
   logic [drc_pkg::DATA_W-1:0]   word_wdata;

   drc_pkg::back_state_type      state_ff, state_in;
   logic [SET_W-1:0]             clr_idx_ff, clr_idx_in;
   logic                         pend_ff, pend_in;
   logic [ADDR_W-1:0]            pend_addr_ff, pend_addr_in;
   logic [BEAT_W-1:0]            beat_ff, beat_in;
   logic [drc_pkg::BYTE_W-1:0]   pend_byte_ff, pend_byte_in;
   logic [ADDR_W-1:0]            lk_addr_ff, lk_addr_in;
   logic [drc_pkg::COUNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [drc_pkg::COUNT_W-1:0]  miss_cnt_ff, miss_cnt_in;

   // address fields of the queue head, the lookup and the pending fill
   logic [SET_W-1:0]             hd_set, lk_set, pd_set;
   logic [OFF_W-1:0]             hd_off, lk_off, pd_off;
   logic [TAG_W-1:0]             lk_tag, pd_tag;
   logic [BEAT_W-1:0]            pd_target;
   logic                         lk_hit, last_beat, target_beat;

   always_comb begin
      hd_set    = SET_W'(head.addr >> OFF_W);
      hd_off    = head.addr[OFF_W-1:0];
      lk_set    = SET_W'(lk_addr_ff >> OFF_W);
      lk_off    = lk_addr_ff[OFF_W-1:0];
      lk_tag    = TAG_W'(lk_addr_ff >> TAG_LSB);
      pd_set    = SET_W'(pend_addr_ff >> OFF_W);
      pd_off    = pend_addr_ff[OFF_W-1:0];
      pd_tag    = TAG_W'(pend_addr_ff >> TAG_LSB);
      pd_target = BEAT_W'(pd_off >> SEL_W);
      lk_hit    = tag_rd_ff[TAG_W] && (tag_rd_ff[TAG_W-1:0] == lk_tag);
      last_beat   = (beat_ff == LAST_BEAT);
      target_beat = (beat_ff == pd_target);
   end

   assign hits   = hit_cnt_ff;
   assign misses = miss_cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drc_pkg::BK_CLEAR: begin
            if (clr_idx_ff == LAST_SET) begin
               state_in = drc_pkg::BK_IDLE;
            end
         end
         drc_pkg::BK_IDLE: begin
            if (head_valid && head.op == drc_pkg::OP_READ && !pend_ff) begin
               state_in = drc_pkg::BK_LOOKUP;
            end
         end
         drc_pkg::BK_LOOKUP: begin
            if (res_ready) begin
               state_in = drc_pkg::BK_IDLE;
            end
         end
         default: state_in = drc_pkg::BK_CLEAR;
      endcase
   end

   // outputs, array ports and state updates
   always_comb begin
      ctl.pop      = 1'b0;
      ctl.hold     = (state_ff == drc_pkg::BK_CLEAR);
      res          = '0;
      res_valid    = 1'b0;
      tag_re       = 1'b0;
      tag_raddr    = hd_set;
      tag_we       = 1'b0;
      tag_waddr    = clr_idx_ff;
      tag_wdata    = '0;
      word_re      = 1'b0;
      word_raddr   = (WORD_W'(hd_set) << LOG_BEATS) | WORD_W'(hd_off >> SEL_W);
      word_we      = 1'b0;
      word_waddr   = (WORD_W'(pd_set) << LOG_BEATS) | WORD_W'(beat_ff);
      word_wdata   = head.data;
      clr_idx_in   = clr_idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      beat_in      = beat_ff;
      pend_byte_in = pend_byte_ff;
      lk_addr_in   = lk_addr_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;

      unique case (state_ff)
         // invalidate one set per cycle after reset
         drc_pkg::BK_CLEAR: begin
            tag_we     = 1'b1;
            clr_idx_in = clr_idx_ff + SET_W'(1);
         end

         drc_pkg::BK_IDLE: begin
            if (head_valid) begin
               if (head.op == drc_pkg::OP_READ && !pend_ff) begin
                  // start a lookup: both arrays read at the head address
                  tag_re     = 1'b1;
                  word_re    = 1'b1;
                  ctl.pop    = 1'b1;
                  lk_addr_in = head.addr;
               end else if (head.op == drc_pkg::OP_FILL && pend_ff) begin
                  // refill beat: write the word, keep the wanted byte
                  res_valid = 1'b1;
                  if (last_beat) begin
                     res.status    = drc_pkg::STAT_DATA;
                     res.read_byte = target_beat
                                     ? drc_pkg::byte_of(head.data, pd_off[SEL_W-1:0])
                                     : pend_byte_ff;
                  end else begin
                     res.status = drc_pkg::STAT_BEAT;
                  end
                  if (res_ready) begin
                     ctl.pop = 1'b1;
                     word_we = 1'b1;
                     if (target_beat) begin
                        pend_byte_in = drc_pkg::byte_of(head.data, pd_off[SEL_W-1:0]);
                     end
                     if (last_beat) begin
                        tag_we    = 1'b1;
                        tag_waddr = pd_set;
                        tag_wdata = {1'b1, pd_tag};
                        pend_in   = 1'b0;
                        beat_in   = '0;
                     end else begin
                        beat_in = beat_ff + BEAT_W'(1);
                     end
                  end
               end else begin
                  // read during a refill, or a beat with no refill open
                  res_valid  = 1'b1;
                  res.status = drc_pkg::STAT_ERROR;
                  ctl.pop    = res_ready;
               end
            end
         end

         // compare the tag and answer the read
         drc_pkg::BK_LOOKUP: begin
            res_valid = 1'b1;
            if (lk_hit) begin
               res.status    = drc_pkg::STAT_DATA;
               res.read_byte = drc_pkg::byte_of(word_rd_ff, lk_off[SEL_W-1:0]);
               res.was_hit   = 1'b1;
            end else begin
               res.status         = drc_pkg::STAT_REFILL;
               res.refill_address = lk_addr_ff & ~OFF_ONES;
            end
            if (res_ready) begin
               if (lk_hit) begin
                  hit_cnt_in = hit_cnt_ff + drc_pkg::COUNT_W'(1);
               end else begin
                  miss_cnt_in  = miss_cnt_ff + drc_pkg::COUNT_W'(1);
                  pend_in      = 1'b1;
                  pend_addr_in = lk_addr_ff;
                  beat_in      = '0;
               end
            end
         end

         default: begin
            ctl.hold = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drc_pkg::BK_CLEAR;
         clr_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         pend_addr_ff <= '0;
         beat_ff      <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         pend_ff      <= pend_in;
         pend_addr_ff <= pend_addr_in;
         beat_ff      <= beat_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      lk_addr_ff   <= lk_addr_in;
   end

   // tag array
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      if (tag_re) begin
         tag_rd_ff <= tag_mem[tag_raddr];
      end
   end

   // line data array
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_waddr] <= word_wdata;
      end
      if (word_re) begin
         word_rd_ff <= word_mem[word_raddr];
      end
   end

endmodule

// File: hw/rtl/direct_mapped_read_cache.sv
// top level of the direct-mapped read cache: front, back and result register
//
// Read-only direct-mapped byte cache, NUM_SETS lines of LINE_BYTES bytes.
// Request channel (req_): kind 0 is a byte read, kind 1 is a 64-bit refill
// beat. Every item gives exactly one result item on the rsp_ channel.
// A hit answers with the byte; a miss answers with a refill request for the
// aligned line, after which LINE_BYTES/8 beats are sent in order; the last
// beat answers with the requested byte. Reads during a refill and beats with
// no refill open get an error status.
// A read passes through the back end as a registered tag and data array
// read, then the compare; a beat or an error is answered from the queue head.
// The back end pops no other item while a read is in its compare.
// The front accepts one item per cycle into a 2-entry queue while it has room.
// Reset: synchronous; afterwards a clear pass invalidates every set of the
// tag array, with req_ready low during it.
// A stalled receiver holds the result register; the queue then fills and
// req_ready drops, with no item lost.
module direct_mapped_read_cache #(
   parameter int NUM_SETS   = 8,
   parameter int LINE_BYTES = 32,
   parameter int ADDR_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [drc_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [drc_pkg::DATA_W-1:0]    req_fill_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [drc_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic                          rsp_was_hit,
   output logic [drc_pkg::ADDR_W-1:0]    rsp_refill_address,
   output logic [drc_pkg::COUNT_W-1:0]   rsp_hits_so_far,
   output logic [drc_pkg::COUNT_W-1:0]   rsp_misses_so_far
);

`include "assert_macros.svh"

   drc_pkg::back_ctl_type  ctl;
   drc_pkg::item_type      head;
   logic                   head_valid;
   drc_pkg::result_type    res;
   logic                   res_valid;
   logic                   slot_free;
   logic                   res_fire;
   logic                   refill_fire;
   logic                   hit_fire;
   logic                   rsp_valid_ff, rsp_valid_in;
   drc_pkg::result_type    rsp_item_ff;

   drc_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_byte_address (req_byte_address),
      .req_fill_data    (req_fill_data),
      .ctl              (ctl),
      .head             (head),
      .head_valid       (head_valid)
   );

   drc_back #(
      .NUM_SETS   (NUM_SETS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .ctl        (ctl),
      .res        (res),
      .res_valid  (res_valid),
      .res_ready  (slot_free),
      .hits       (rsp_hits_so_far),
      .misses     (rsp_misses_so_far)
   );

   // result register: loads when empty or being drained
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign res_fire     = res_valid && slot_free;
   assign rsp_valid_in = res_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_item_ff.status;
   assign rsp_read_byte      = rsp_item_ff.read_byte;
   assign rsp_was_hit        = rsp_item_ff.was_hit;
   assign rsp_refill_address = rsp_item_ff.refill_address;

   // result kinds that move the counters
   assign refill_fire = res_fire && (res.status == drc_pkg::STAT_REFILL);
   assign hit_fire    = res_fire && res.was_hit;

   // checks
   `ASSERT_IMPLIES(a_clear_blocks_input, clock, reset, ctl.hold, !req_ready, "item in clear")
   `ASSERT_NEXT(a_miss_on_refill, clock, reset, !refill_fire, $stable(rsp_misses_so_far), "miss")
   `ASSERT_NEXT(a_hit_on_hit, clock, reset, !hit_fire, $stable(rsp_hits_so_far), "stray hit")

endmodule
